>>> hdl/tvms_pkg.sv
// shared types, constants and helpers of the two-view model score block
package tvms_pkg;

   localparam int PT_W       = 16;
   localparam int COEF_W     = 21;
   localparam int ROW_W      = 63;
   localparam int SCORE_W    = 32;
   localparam int COUNT_W    = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int DEF_MAX_POINTS = 65536;

   // shared multiplier and divider widths
   localparam int MUL_A_W = 40;
   localparam int MUL_B_W = 28;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int DIVD_W  = 64;
   localparam int DIVS_W  = 42;
   localparam int DCNT_W  = $clog2(DIVD_W);

   // error thresholds and gain, unsigned Q.16
   localparam logic [31:0] TH_H  = 32'd392626;
   localparam logic [31:0] TH_F  = 32'd251724;
   localparam logic [18:0] GAMMA = 19'd392626;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE  = 3'd0,
      CSR_MROW0 = 3'd1,
      CSR_MROW1 = 3'd2,
      CSR_MROW2 = 3'd3,
      CSR_GROW0 = 3'd4,
      CSR_GROW1 = 3'd5,
      CSR_GROW2 = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

   // one signed Q1.19 coefficient out of a packed row
   function automatic logic signed [COEF_W-1:0] coef_of(input logic [ROW_W-1:0] row,
                                                        input logic [1:0] col);
      logic signed [COEF_W-1:0] c;
      unique case (col)
         2'd0:    c = signed'(row[COEF_W-1:0]);
         2'd1:    c = signed'(row[2*COEF_W-1:COEF_W]);
         default: c = signed'(row[3*COEF_W-1:2*COEF_W]);
      endcase
      return c;
   endfunction

endpackage

>>> hdl/tvms_mul.sv
// shared signed multiplier with registered product
module tvms_mul (
   input  logic                                  clock,
   input  logic signed [tvms_pkg::MUL_A_W-1:0]   op_a,
   input  logic signed [tvms_pkg::MUL_B_W-1:0]   op_b,
   output logic signed [tvms_pkg::PROD_W-1:0]    product
);
   import tvms_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);
   assign product = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> hdl/tvms_div.sv
// restoring unsigned divider, one quotient bit per cycle
module tvms_div (
   input  logic                      clock,
   input  logic                      reset,
   input  tvms_pkg::div_req_type     req,
   output tvms_pkg::div_rsp_type     rsp
);
   import tvms_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;
   logic [DIVS_W:0]   rem_sh;
   logic [DIVS_W:0]   trial;
   logic              fits;

   assign rem_sh = {rem_ff, quo_ff[DIVD_W-1]};
   assign trial  = rem_sh - {1'b0, dvs_ff};
   assign fits   = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> hdl/two_view_model_score.sv
// Two-view model scorer: one correspondence at a time through a shared multiplier and divider.
// A homography point works each direction through nine multiply-accumulate pairs for the
// projected point, then two divisions, each followed by squaring the difference, and then
// the score. A fundamental point works each direction through the line, the numerator, the
// normalisation of the line, the denominator and the squared numerator, and one division.
// A direction with a zero divisor, or with a point far from its line, ends early. The input
// stalls while a point is in work; a finished result waits in the output register while the
// next set is scored. Configuration must be written only while idle; the block itself does
// not enforce it.
module two_view_model_score #(
   parameter int MAX_POINTS = tvms_pkg::DEF_MAX_POINTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tvms_pkg::PT_W-1:0]         req_point_one_x,
   input  logic [tvms_pkg::PT_W-1:0]         req_point_one_y,
   input  logic [tvms_pkg::PT_W-1:0]         req_point_two_x,
   input  logic [tvms_pkg::PT_W-1:0]         req_point_two_y,
   input  logic                              req_last_point,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tvms_pkg::SCORE_W-1:0]      rsp_total_score,
   output logic [tvms_pkg::COUNT_W-1:0]      rsp_point_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tvms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tvms_pkg::ROW_W-1:0]        csr_data
);
   import tvms_pkg::*;

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int ACC_W  = 64;
   localparam int LINE_W = MUL_A_W;
   localparam int DIFF_W = 18;
   localparam int U_W    = 50;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LINE_MUL, ST_LINE_ACC, ST_DIV_GO, ST_DIV_WAIT, ST_SQ_MUL, ST_SQ_ACC,
      ST_NUM_MUL, ST_NUM_ACC, ST_EPI_CHECK, ST_EPI_SHIFT, ST_DEN_MUL, ST_DEN_ACC,
      ST_NN_MUL, ST_NN_ACC, ST_FDIV_WAIT, ST_SCORE, ST_DIR_END, ST_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic                      dir_ff, dir_in;
   logic [1:0]                row_ff, row_in;
   logic [1:0]                term_ff, term_in;
   logic                      crd_ff, crd_in;
   logic                      sgn_ff, sgn_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [LINE_W-1:0]  v_ff [3];
   logic signed [LINE_W-1:0]  v_in [3];
   logic [PT_W-1:0]           p1x_ff, p1x_in, p1y_ff, p1y_in;
   logic [PT_W-1:0]           p2x_ff, p2x_in, p2y_ff, p2y_in;
   logic                      last_ff, last_in;
   logic signed [DIFF_W-1:0]  d_ff, d_in;
   logic [33:0]               eacc_ff, eacc_in;
   logic [31:0]               e_ff, e_in;
   logic [LINE_W-1:0]         a0_ff, a0_in, a1_ff, a1_in, m_ff, m_in;
   logic [55:0]               n_ff, n_in;
   logic [DIVS_W-1:0]         den_ff, den_in;
   logic [SCORE_W-1:0]        score_ff, score_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0]        rsp_total_ff, rsp_total_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                      mode_ff, mode_in;
   logic [ROW_W-1:0]          mrow_ff [3];
   logic [ROW_W-1:0]          mrow_in [3];
   logic [ROW_W-1:0]          grow_ff [3];
   logic [ROW_W-1:0]          grow_in [3];

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   logic [PT_W-1:0]           src_x, src_y, tgt_x, tgt_y, tc;
   logic signed [COEF_W-1:0]  coef_sel;
   logic signed [MUL_B_W-1:0] line_op, num_op;
   logic signed [ACC_W-1:0]   msum;
   logic [LINE_W-1:0]         ma0, ma1, mm, mq0, mq1, mq2, mqc;
   logic [ACC_W-1:0]          mn64;
   logic signed [U_W-1:0]     qs, u, diffv;
   logic [33:0]               esum;
   logic [31:0]               limit;
   logic [18:0]               gdiff;
   logic [SCORE_W:0]          ssum;
   logic [CNT_W-1:0]          cnt_next;
   logic [CNT_W+COUNT_W-1:0]  cnt_ext;
   logic                      out_free;

   tvms_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   tvms_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      dir_in       = dir_ff;
      row_in       = row_ff;
      term_in      = term_ff;
      crd_in       = crd_ff;
      sgn_in       = sgn_ff;
      acc_in       = acc_ff;
      for (int i = 0; i < 3; i++) begin
         v_in[i]    = v_ff[i];
         mrow_in[i] = mrow_ff[i];
         grow_in[i] = grow_ff[i];
      end
      p1x_in       = p1x_ff;
      p1y_in       = p1y_ff;
      p2x_in       = p2x_ff;
      p2y_in       = p2y_ff;
      last_in      = last_ff;
      d_in         = d_ff;
      eacc_in      = eacc_ff;
      e_in         = e_ff;
      a0_in        = a0_ff;
      a1_in        = a1_ff;
      m_in         = m_ff;
      n_in         = n_ff;
      den_in       = den_ff;
      score_in     = score_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_total_in = rsp_total_ff;
      rsp_count_in = rsp_count_ff;
      mode_in      = mode_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_req      = '0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:  mode_in    = csr_data[0];
            CSR_MROW0: mrow_in[0] = csr_data;
            CSR_MROW1: mrow_in[1] = csr_data;
            CSR_MROW2: mrow_in[2] = csr_data;
            CSR_GROW0: grow_in[0] = csr_data;
            CSR_GROW1: grow_in[1] = csr_data;
            CSR_GROW2: grow_in[2] = csr_data;
            default: ;
         endcase
      end

      // direction 0 maps image one onto image two, direction 1 the other way
      src_x = dir_ff ? p2x_ff : p1x_ff;
      src_y = dir_ff ? p2y_ff : p1y_ff;
      tgt_x = dir_ff ? p1x_ff : p2x_ff;
      tgt_y = dir_ff ? p1y_ff : p2y_ff;

      if (!mode_ff) begin
         coef_sel = coef_of(dir_ff ? grow_ff[row_ff] : mrow_ff[row_ff], term_ff);
      end else if (!dir_ff) begin
         coef_sel = coef_of(mrow_ff[row_ff], term_ff);
      end else begin
         // transposed matrix for the line in image one
         coef_sel = coef_of(mrow_ff[term_ff], row_ff);
      end

      priority case (term_ff)
         2'd0:    line_op = signed'({12'b0, src_x});
         2'd1:    line_op = signed'({12'b0, src_y});
         default: line_op = MUL_B_W'(16);
      endcase
      priority case (term_ff)
         2'd0:    num_op = signed'({12'b0, tgt_x});
         2'd1:    num_op = signed'({12'b0, tgt_y});
         default: num_op = MUL_B_W'(16);
      endcase

      msum = acc_ff + signed'(prod[ACC_W-1:0]);

      ma0  = v_ff[0][LINE_W-1] ? LINE_W'(-v_ff[0]) : LINE_W'(v_ff[0]);
      ma1  = v_ff[1][LINE_W-1] ? LINE_W'(-v_ff[1]) : LINE_W'(v_ff[1]);
      mm   = (ma0 > ma1) ? ma0 : ma1;
      mn64 = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      mq0  = ma0;
      mq1  = ma1;
      mq2  = v_ff[2][LINE_W-1] ? LINE_W'(-v_ff[2]) : LINE_W'(v_ff[2]);
      mqc  = crd_ff ? mq1 : mq0;

      qs    = signed'({1'b0, div_rsp.quotient[U_W-2:0]});
      u     = sgn_ff ? -qs : qs;
      tc    = crd_ff ? tgt_y : tgt_x;
      diffv = u - signed'({30'b0, tc, 4'b0});
      esum  = eacc_ff + prod[33:0];

      limit = mode_ff ? TH_F : TH_H;
      gdiff = GAMMA - e_ff[18:0];
      ssum  = {1'b0, score_ff} + {{(SCORE_W - 10){1'b0}}, gdiff[18:8]};

      cnt_next = (cnt_ff < CNT_W'(MAX_POINTS)) ? cnt_ff + 1'b1 : cnt_ff;
      cnt_ext  = {{COUNT_W{1'b0}}, cnt_next};
      out_free = !rsp_valid_ff || !rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               p1x_in   = req_point_one_x;
               p1y_in   = req_point_one_y;
               p2x_in   = req_point_two_x;
               p2y_in   = req_point_two_y;
               last_in  = req_last_point;
               dir_in   = 1'b0;
               row_in   = '0;
               term_in  = '0;
               crd_in   = 1'b0;
               acc_in   = '0;
               state_in = ST_LINE_MUL;
            end
         end
         ST_LINE_MUL: begin
            mul_a    = MUL_A_W'(coef_sel);
            mul_b    = line_op;
            state_in = ST_LINE_ACC;
         end
         ST_LINE_ACC: begin
            state_in = ST_LINE_MUL;
            if (term_ff == 2'd2) begin
               v_in[row_ff] = msum[LINE_W-1:0];
               acc_in       = '0;
               term_in      = '0;
               if (row_ff == 2'd2) begin
                  row_in   = '0;
                  state_in = mode_ff ? ST_NUM_MUL : ST_DIV_GO;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               acc_in  = msum;
               term_in = term_ff + 1'b1;
            end
         end
         ST_DIV_GO: begin
            if (v_ff[2] == '0) begin
               state_in = ST_DIR_END;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {{(DIVD_W - LINE_W - 8){1'b0}}, mqc, 8'b0};
               div_req.divisor  = {{(DIVS_W - LINE_W){1'b0}}, mq2};
               sgn_in           = (crd_ff ? v_ff[1][LINE_W-1] : v_ff[0][LINE_W-1])
                                  ^ v_ff[2][LINE_W-1];
               if (!crd_ff) begin
                  eacc_in = '0;
               end
               state_in = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               // transfer difference saturates at 256 px
               priority if (diffv > U_W'(65536)) begin
                  d_in = DIFF_W'(65536);
               end else if (diffv < -U_W'(65536)) begin
                  d_in = -DIFF_W'(65536);
               end else begin
                  d_in = diffv[DIFF_W-1:0];
               end
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            mul_a    = MUL_A_W'(d_ff);
            mul_b    = MUL_B_W'(d_ff);
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            if (!crd_ff) begin
               eacc_in  = esum;
               crd_in   = 1'b1;
               state_in = ST_DIV_GO;
            end else begin
               crd_in   = 1'b0;
               e_in     = (esum[33:32] != 2'b0) ? '1 : esum[31:0];
               state_in = ST_SCORE;
            end
         end
         ST_NUM_MUL: begin
            mul_a    = v_ff[term_ff];
            mul_b    = num_op;
            state_in = ST_NUM_ACC;
         end
         ST_NUM_ACC: begin
            acc_in = msum;
            if (term_ff == 2'd2) begin
               term_in  = '0;
               state_in = ST_EPI_CHECK;
            end else begin
               term_in  = term_ff + 1'b1;
               state_in = ST_NUM_MUL;
            end
         end
         ST_EPI_CHECK: begin
            // no line, or point far from the line: nothing to add
            if (mm == '0 || mn64 >= {18'b0, mm, 6'b0}) begin
               state_in = ST_DIR_END;
            end else begin
               a0_in    = ma0;
               a1_in    = ma1;
               m_in     = mm;
               n_in     = mn64[55:0];
               state_in = ST_EPI_SHIFT;
            end
         end
         ST_EPI_SHIFT: begin
            if (m_ff[LINE_W-1:20] != '0) begin
               a0_in = a0_ff >> 1;
               a1_in = a1_ff >> 1;
               m_in  = m_ff >> 1;
               n_in  = n_ff >> 1;
            end else begin
               term_in  = '0;
               acc_in   = '0;
               state_in = ST_DEN_MUL;
            end
         end
         ST_DEN_MUL: begin
            mul_a    = signed'({20'b0, term_ff[0] ? a1_ff[19:0] : a0_ff[19:0]});
            mul_b    = signed'({8'b0, term_ff[0] ? a1_ff[19:0] : a0_ff[19:0]});
            state_in = ST_DEN_ACC;
         end
         ST_DEN_ACC: begin
            if (!term_ff[0]) begin
               acc_in   = msum;
               term_in  = 2'd1;
               state_in = ST_DEN_MUL;
            end else begin
               den_in   = msum[DIVS_W-1:0];
               term_in  = '0;
               state_in = ST_NN_MUL;
            end
         end
         ST_NN_MUL: begin
            mul_a    = signed'({13'b0, n_ff[26:0]});
            mul_b    = signed'({1'b0, n_ff[26:0]});
            state_in = ST_NN_ACC;
         end
         ST_NN_ACC: begin
            div_req.start    = 1'b1;
            div_req.dividend = {prod[DIVD_W-9:0], 8'b0};
            div_req.divisor  = den_ff;
            state_in         = ST_FDIV_WAIT;
         end
         ST_FDIV_WAIT: begin
            if (div_rsp.done) begin
               e_in     = (div_rsp.quotient[DIVD_W-1:32] != '0) ? '1
                          : div_rsp.quotient[31:0];
               state_in = ST_SCORE;
            end
         end
         ST_SCORE: begin
            if (e_ff < limit) begin
               score_in = ssum[SCORE_W] ? '1 : ssum[SCORE_W-1:0];
            end
            state_in = ST_DIR_END;
         end
         ST_DIR_END: begin
            if (!dir_ff) begin
               dir_in   = 1'b1;
               row_in   = '0;
               term_in  = '0;
               crd_in   = 1'b0;
               acc_in   = '0;
               state_in = ST_LINE_MUL;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!last_ff) begin
               cnt_in   = cnt_next;
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = score_ff;
               rsp_count_in = cnt_ext[COUNT_W-1:0];
               score_in     = '0;
               cnt_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         score_ff     <= '0;
         cnt_ff       <= '0;
         mode_ff      <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            mrow_ff[i] <= '0;
            grow_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         score_ff     <= score_in;
         cnt_ff       <= cnt_in;
         mode_ff      <= mode_in;
         for (int i = 0; i < 3; i++) begin
            mrow_ff[i] <= mrow_in[i];
            grow_ff[i] <= grow_in[i];
         end
      end
      dir_ff       <= dir_in;
      row_ff       <= row_in;
      term_ff      <= term_in;
      crd_ff       <= crd_in;
      sgn_ff       <= sgn_in;
      acc_ff       <= acc_in;
      for (int i = 0; i < 3; i++) begin
         v_ff[i] <= v_in[i];
      end
      p1x_ff       <= p1x_in;
      p1y_ff       <= p1y_in;
      p2x_ff       <= p2x_in;
      p2y_ff       <= p2y_in;
      last_ff      <= last_in;
      d_ff         <= d_in;
      eacc_ff      <= eacc_in;
      e_ff         <= e_in;
      a0_ff        <= a0_in;
      a1_ff        <= a1_in;
      m_ff         <= m_in;
      n_ff         <= n_in;
      den_ff       <= den_in;
      rsp_total_ff <= rsp_total_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_total_score = rsp_total_ff;
   assign rsp_point_count = rsp_count_ff;
   assign csr_ready       = 1'b1;

endmodule

>>> verif/two_view_model_score_checker.sv
// checker for the two-view model score block: predicts each set score and compares results
`timescale 1ns / 1ps

module two_view_model_score_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [tvms_pkg::PT_W-1:0]      req_point_one_x,
   input  logic [tvms_pkg::PT_W-1:0]      req_point_one_y,
   input  logic [tvms_pkg::PT_W-1:0]      req_point_two_x,
   input  logic [tvms_pkg::PT_W-1:0]      req_point_two_y,
   input  logic                           req_last_point,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [tvms_pkg::SCORE_W-1:0]   rsp_total_score,
   input  logic [tvms_pkg::COUNT_W-1:0]   rsp_point_count,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [tvms_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tvms_pkg::ROW_W-1:0]     csr_data,
   output int                             failures,
   output int                             pending
);
   import tvms_pkg::*;

   localparam longint unsigned HOMOG_LIMIT = 64'd392626;
   localparam longint unsigned FUND_LIMIT  = 64'd251724;
   localparam longint unsigned GAIN_Q16    = 64'd392626;
   localparam longint          DIFF_CLAMP  = 64'sd65536;
   localparam int              POINT_CAP   = 65536;

   typedef struct packed {
      logic [SCORE_W-1:0] total_score;
      logic [COUNT_W-1:0] point_count;
   } set_score_type;

   logic                 fund_mode;
   logic [ROW_W-1:0]     model_rows[3];
   logic [ROW_W-1:0]     inverse_rows[3];
   logic [SCORE_W-1:0]   score_acc;
   int                   points_in_set;
   set_score_type        expected_scores[$];

   assign pending = expected_scores.size();

   function automatic longint coef_at(input logic [ROW_W-1:0] row, input int col);
      logic signed [COEF_W-1:0] c;
      c = row[col*COEF_W +: COEF_W];
      return longint'(c);
   endfunction

   function automatic void add_score(input longint unsigned err, input longint unsigned lim);
      longint unsigned sum;
      if (err > 64'hFFFF_FFFF) err = 64'hFFFF_FFFF;
      if (err >= lim) return;
      sum = longint'(score_acc) + ((GAIN_Q16 - err) >> 8);
      score_acc = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   function automatic longint clamp_diff(input longint d);
      if (d > DIFF_CLAMP) return DIFF_CLAMP;
      if (d < -DIFF_CLAMP) return -DIFF_CLAMP;
      return d;
   endfunction

   // forward or backward transfer error of one point through a matrix
   function automatic void transfer_error(input logic [ROW_W-1:0] rows[3],
                                          input longint sx, input longint sy,
                                          input longint tx, input longint ty);
      longint q[3];
      longint dx, dy;
      for (int r = 0; r < 3; r++)
         q[r] = coef_at(rows[r], 0) * sx + coef_at(rows[r], 1) * sy + coef_at(rows[r], 2) * 16;
      if (q[2] == 0) return;
      dx = clamp_diff((q[0] * 256) / q[2] - tx * 16);
      dy = clamp_diff((q[1] * 256) / q[2] - ty * 16);
      add_score(longint'(dx * dx) + longint'(dy * dy), HOMOG_LIMIT);
   endfunction

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // squared distance from the epipolar line, after normalising the line to 20 bits
   function automatic void line_error(input longint l0, input longint l1, input longint num);
      longint unsigned a0, a1, n, m, den;
      int s;
      a0 = magnitude(l0);
      a1 = magnitude(l1);
      n  = magnitude(num);
      m  = (a0 > a1) ? a0 : a1;
      s  = 0;
      if (m == 0) return;
      if (n >= 64 * m) return;
      while ((m >> s) >= (64'd1 << 20)) s++;
      a0 = a0 >> s;
      a1 = a1 >> s;
      n  = n >> s;
      den = a0 * a0 + a1 * a1;
      if (den == 0) return;
      add_score(((n * n) << 8) / den, FUND_LIMIT);
   endfunction

   function automatic void score_point(input longint x1, input longint y1,
                                       input longint x2, input longint y2);
      longint a[3], b[3];
      if (!fund_mode) begin
         transfer_error(model_rows, x1, y1, x2, y2);
         transfer_error(inverse_rows, x2, y2, x1, y1);
      end else begin
         for (int i = 0; i < 3; i++) begin
            a[i] = coef_at(model_rows[i], 0) * x1 + coef_at(model_rows[i], 1) * y1
                   + coef_at(model_rows[i], 2) * 16;
            b[i] = coef_at(model_rows[0], i) * x2 + coef_at(model_rows[1], i) * y2
                   + coef_at(model_rows[2], i) * 16;
         end
         line_error(a[0], a[1], a[0] * x2 + a[1] * y2 + a[2] * 16);
         line_error(b[0], b[1], b[0] * x1 + b[1] * y1 + b[2] * 16);
      end
   endfunction

   always @(posedge clock) begin
      set_score_type got, want;
      if (reset) begin
         fund_mode     = 1'b0;
         model_rows    = '{default: '0};
         inverse_rows  = '{default: '0};
         score_acc     = '0;
         points_in_set = 0;
         expected_scores.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_MODE:  fund_mode = csr_data[0];
               CSR_MROW0: model_rows[0] = csr_data;
               CSR_MROW1: model_rows[1] = csr_data;
               CSR_MROW2: model_rows[2] = csr_data;
               CSR_GROW0: inverse_rows[0] = csr_data;
               CSR_GROW1: inverse_rows[1] = csr_data;
               CSR_GROW2: inverse_rows[2] = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            score_point(longint'(req_point_one_x), longint'(req_point_one_y),
                        longint'(req_point_two_x), longint'(req_point_two_y));
            if (points_in_set < POINT_CAP) points_in_set++;
            if (req_last_point) begin
               want = '{score_acc, points_in_set[COUNT_W-1:0]};
               expected_scores.insert(expected_scores.size(), want);
               score_acc     = '0;
               points_in_set = 0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_total_score, rsp_point_count};
            if (expected_scores.size() == 0) begin
               $display("%0t: unexpected result score %0d count %0d", $realtime,
                        got.total_score, got.point_count);
               failures++;
            end else begin
               want = expected_scores.pop_front();
               if (got.total_score !== want.total_score) begin
                  $display("%0t: total_score expected %0d actual %0d", $realtime,
                           want.total_score, got.total_score);
                  failures++;
               end
               if (got.point_count !== want.point_count) begin
                  $display("%0t: point_count expected %0d actual %0d", $realtime,
                           want.point_count, got.point_count);
                  failures++;
               end
            end
         end
      end
   end

   initial failures = 0;

endmodule

>>> verif/testbench.sv
// stimulus and verdict for the two-view model score block
`timescale 1ns / 1ps

module testbench;
   import tvms_pkg::*;

   localparam int ONE_Q19    = 1 << 19;
   localparam int COEF_MAX   = (1 << 20) - 1;
   localparam int COEF_MIN   = -(1 << 20);
   localparam int DRAIN_WAIT = 400;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [PT_W-1:0]      req_point_one_x, req_point_one_y;
   logic [PT_W-1:0]      req_point_two_x, req_point_two_y;
   logic                 req_last_point;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [SCORE_W-1:0]   rsp_total_score;
   logic [COUNT_W-1:0]   rsp_point_count;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ROW_W-1:0]     csr_data;
   int                   failures, pending;
   int                   burst_left;
   bit                   fund_now;

   two_view_model_score dut (.*);

   two_view_model_score_checker checker_i (.*);

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   // receiver: stall pattern picked at random from four modes, with one long hold-off
   initial begin
      int cyc, mode;
      cyc = 0;
      mode = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 500 == 0) mode = $urandom_range(0, 3);
         if (cyc >= 30000 && cyc < 34000)
            rsp_stall <= 1'b1;
         else case (mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 9) < 3);
            2:       rsp_stall <= ($urandom_range(0, 9) < 8);
            default: rsp_stall <= ((cyc / 16) % 2 == 1);
         endcase
      end
   end

   function automatic logic [ROW_W-1:0] pack_row(input int c0, input int c1, input int c2);
      logic [COEF_W-1:0] a, b, c;
      a = COEF_W'(c0);
      b = COEF_W'(c1);
      c = COEF_W'(c2);
      return {c, b, a};
   endfunction

   function automatic int jitter(input int k);
      return int'($urandom_range(0, 2 * k)) - k;
   endfunction

   task automatic csr_write(input csr_index_type idx, input logic [ROW_W-1:0] data);
      bit go;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do begin
         @(negedge clock);
         go = csr_ready;
         @(posedge clock);
      end while (!go);
   endtask

   task automatic load_model(input bit fund, input logic [ROW_W-1:0] m[3],
                             input logic [ROW_W-1:0] g[3]);
      csr_write(CSR_MODE, {62'(0), fund});
      csr_write(CSR_MROW0, m[0]);
      csr_write(CSR_MROW1, m[1]);
      csr_write(CSR_MROW2, m[2]);
      csr_write(CSR_GROW0, g[0]);
      csr_write(CSR_GROW1, g[1]);
      csr_write(CSR_GROW2, g[2]);
      csr_valid <= 1'b0;
      fund_now = fund;
   endtask

   // wait for every expected set score, then let any unfinished point drain
   task automatic settle();
      bit idle;
      if (req_valid) begin
         req_valid <= 1'b0;
         burst_left = 0;
      end
      do begin
         @(negedge clock);
         idle = (pending == 0);
      end while (!idle);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic send_point(input int x1, input int y1, input int x2, input int y2,
                             input bit last);
      bit go;
      req_valid       <= 1'b1;
      req_point_one_x <= PT_W'(x1);
      req_point_one_y <= PT_W'(y1);
      req_point_two_x <= PT_W'(x2);
      req_point_two_y <= PT_W'(y2);
      req_last_point  <= last;
      do begin
         @(negedge clock);
         go = !req_stall;
         @(posedge clock);
      end while (!go);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   // a set of mostly near-matching correspondences with some noise points
   task automatic send_set(input int len);
      int x1, y1, x2, y2;
      for (int i = 0; i < len; i++) begin
         x1 = $urandom_range(0, 65535);
         y1 = $urandom_range(0, 65535);
         if ($urandom_range(0, 9) < 7) begin
            x2 = fund_now ? $urandom_range(0, 65535) : (x1 + jitter(40)) & 16'hFFFF;
            y2 = (y1 + jitter(40)) & 16'hFFFF;
         end else begin
            x2 = $urandom_range(0, 65535);
            y2 = $urandom_range(0, 65535);
         end
         send_point(x1, y1, x2, y2, i == len - 1);
      end
   endtask

   task automatic random_model();
      logic [ROW_W-1:0] m[3], g[3];
      int kind, k;
      bit fund;
      kind = $urandom_range(0, 5);
      fund = $urandom_range(0, 1);
      case (kind)
         0, 1: begin
            // near identity homography, small translation
            fund = 1'b0;
            m[0] = pack_row(ONE_Q19 + jitter(64), jitter(64), jitter(2000));
            m[1] = pack_row(jitter(64), ONE_Q19 + jitter(64), jitter(2000));
            m[2] = pack_row(jitter(2), jitter(2), ONE_Q19 + jitter(64));
            g[0] = pack_row(ONE_Q19 + jitter(64), jitter(64), jitter(2000));
            g[1] = pack_row(jitter(64), ONE_Q19 + jitter(64), jitter(2000));
            g[2] = pack_row(jitter(2), jitter(2), ONE_Q19 + jitter(64));
         end
         2, 3: begin
            // sideways translation: epipolar lines are rows
            fund = 1'b1;
            k = $urandom_range(1 << 10, ONE_Q19);
            m[0] = pack_row(jitter(3), jitter(3), jitter(3));
            m[1] = pack_row(jitter(3), jitter(3), -k);
            m[2] = pack_row(jitter(3), k, jitter(3));
            for (int r = 0; r < 3; r++) g[r] = ROW_W'({$urandom, $urandom});
         end
         4: for (int r = 0; r < 3; r++) begin
            m[r] = ROW_W'({$urandom, $urandom});
            g[r] = ROW_W'({$urandom, $urandom});
         end
         default: begin
            k = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
            for (int r = 0; r < 3; r++) begin
               m[r] = pack_row(k, $urandom_range(0, 1) ? COEF_MAX : COEF_MIN, k);
               g[r] = pack_row(COEF_MIN, k, COEF_MAX);
            end
         end
      endcase
      load_model(fund, m, g);
   endtask

   initial begin
      logic [ROW_W-1:0] m[3], g[3];
      int sent, len;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_point_one_x = '0;
      req_point_one_y = '0;
      req_point_two_x = '0;
      req_point_two_y = '0;
      req_last_point  = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      burst_left      = 0;
      fund_now        = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero matrix after reset: every divisor is zero
      send_point(0, 0, 0, 0, 1'b0);
      send_point(65535, 65535, 65535, 65535, 1'b1);
      settle();

      // exact identity homography
      m[0] = pack_row(ONE_Q19, 0, 0);
      m[1] = pack_row(0, ONE_Q19, 0);
      m[2] = pack_row(0, 0, ONE_Q19);
      load_model(1'b0, m, m);
      send_point(1000, 2000, 1000, 2000, 1'b1);
      send_point(0, 0, 0, 0, 1'b0);
      send_point(65535, 65535, 65535, 65535, 1'b0);
      send_point(1000, 1000, 1030, 1000, 1'b0);
      send_point(65535, 65535, 0, 0, 1'b0);
      send_point(4000, 500, 4010, 495, 1'b1);
      settle();

      // sideways translation fundamental matrix
      m[0] = pack_row(0, 0, 0);
      m[1] = pack_row(0, 0, -ONE_Q19);
      m[2] = pack_row(0, ONE_Q19, 0);
      load_model(1'b1, m, m);
      send_point(100, 800, 9000, 800, 1'b0);
      send_point(100, 800, 9000, 820, 1'b0);
      send_point(100, 800, 9000, 60000, 1'b0);
      send_point(65535, 0, 0, 65535, 1'b0);
      send_point(0, 65535, 65535, 65535, 1'b1);
      settle();

      // extreme coefficients
      for (int r = 0; r < 3; r++) begin
         m[r] = pack_row(COEF_MAX, COEF_MIN, COEF_MAX);
         g[r] = pack_row(COEF_MIN, COEF_MAX, COEF_MIN);
      end
      load_model(1'b0, m, g);
      send_point(65535, 0, 12345, 65535, 1'b0);
      send_point(1, 2, 3, 4, 1'b1);
      settle();
      load_model(1'b1, g, m);
      send_point(65535, 65535, 0, 1, 1'b1);
      settle();

      sent = 0;
      while (sent < 550) begin
         random_model();
         for (int s = 0; s < $urandom_range(3, 8); s++) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            send_set(len);
            sent += len;
         end
         settle();
      end

      if (failures == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

>>> two_view_model_score.f
hdl/tvms_pkg.sv
hdl/tvms_mul.sv
hdl/tvms_div.sv
hdl/two_view_model_score.sv
verif/two_view_model_score_checker.sv
verif/testbench.sv
